// ===== hw/rtl/sid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants of the set intersection engine.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int CAPACITY_DEFAULT = 256;
    localparam int KEY_W            = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OPC_INSERT = 2'd0;
    localparam logic [1:0] OPC_PROBE  = 2'd1;
    localparam logic [1:0] OPC_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        CLS_INSERT,
        CLS_PROBE,
        CLS_CLEAR,
        CLS_IGNORE
    } op_class_t;

    typedef struct packed {
        op_class_t          cls;
        logic [KEY_W-1:0]   key;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } back_state_t;

endpackage

// ===== hw/rtl/sid_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_front
// Accepts requests, decodes the opcode and holds them in a short queue.
// ----------------------------------------------------------------------------
module sid_front import sid_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic signed [KEY_W-1:0] s_key,
    output logic                    q_valid,
    input  logic                    q_ready,
    output item_t                   q_item
);

    item_t            buf_mem [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   fill_reg, fill_next;
    logic             push, pop;
    item_t            in_item;

    always_comb begin
        case (s_opcode)
            OPC_INSERT: in_item.cls = CLS_INSERT;
            OPC_PROBE:  in_item.cls = CLS_PROBE;
            OPC_CLEAR:  in_item.cls = CLS_CLEAR;
            default:    in_item.cls = CLS_IGNORE;
        endcase
        in_item.key = s_key;
    end

    assign s_ready = (fill_reg != QCW'(QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = buf_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + QCW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= in_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + QCW'(1)))
        else $error("Queue fill did not grow on a lone push.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (fill_reg == $past(fill_reg) - QCW'(1)))
        else $error("Queue fill did not shrink on a lone pop.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= QCW'(QUEUE_DEPTH))
        else $error("Queue fill exceeds the queue depth.");

endmodule

// ===== hw/rtl/sid_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_back
// Executes queued requests: sequential key table scan, table update and the
// result register.
// ----------------------------------------------------------------------------
module sid_back import sid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  item_t                   q_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_emit,
    output logic signed [KEY_W-1:0] m_match_key,
    output logic                    m_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_W-1:0] key_mem     [CAPACITY];
    logic             emitted_mem [CAPACITY];

    back_state_t      state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             m_valid_reg, m_valid_next;
    op_class_t        cls_reg;
    logic [KEY_W-1:0] key_reg;
    logic [AW-1:0]    rd_idx_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic             rd_emitted_reg;
    logic             res_emit_reg, res_emit_next;
    logic             res_status_reg, res_status_next;
    logic             m_emit_reg;
    logic [KEY_W-1:0] m_key_reg;
    logic             m_status_reg;

    logic             rd_en;
    logic             wr_key_en;
    logic             wr_emit_en;
    logic             wr_emit_val;
    logic [AW-1:0]    wr_addr;
    logic             hit;
    logic             last;
    logic             miss;
    logic             out_load;
    logic             take;

    assign q_ready     = (state_reg == ST_IDLE);
    assign take        = q_valid && q_ready;
    assign m_valid     = m_valid_reg;
    assign m_emit      = m_emit_reg;
    assign m_match_key = m_key_reg;
    assign m_status    = m_status_reg;

    assign hit  = rd_pend_reg && (rd_key_reg == key_reg);
    assign last = rd_pend_reg ? ((CW'(rd_idx_reg) + CW'(1)) == count_reg)
                              : (issue_reg >= count_reg);
    assign miss = !hit && last;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        rd_pend_next    = rd_pend_reg;
        res_emit_next   = res_emit_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        rd_en           = 1'b0;
        wr_key_en       = 1'b0;
        wr_emit_en      = 1'b0;
        wr_emit_val     = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    res_emit_next   = 1'b0;
                    res_status_next = 1'b0;
                    case (q_item.cls)
                        CLS_INSERT, CLS_PROBE: begin
                            issue_next   = '0;
                            rd_pend_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        CLS_CLEAR: begin
                            count_next = '0;
                            state_next = ST_RESULT;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                rd_en        = (issue_reg < count_reg);
                rd_pend_next = rd_en;
                if (rd_en) begin
                    issue_next = issue_reg + CW'(1);
                end
                if (hit || miss) begin
                    rd_pend_next = 1'b0;
                    state_next   = ST_RESULT;
                    if (cls_reg == CLS_INSERT && miss) begin
                        if (count_reg < CW'(CAPACITY)) begin
                            wr_key_en  = 1'b1;
                            wr_emit_en = 1'b1;
                            count_next = count_reg + CW'(1);
                        end else begin
                            res_status_next = 1'b1;
                        end
                    end else if (cls_reg == CLS_PROBE && hit && !rd_emitted_reg) begin
                        wr_emit_en    = 1'b1;
                        wr_emit_val   = 1'b1;
                        wr_addr       = rd_idx_reg;
                        res_emit_next = 1'b1;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            issue_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issue_reg   <= issue_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_emit_reg   <= res_emit_next;
        res_status_reg <= res_status_next;
        if (take) begin
            cls_reg <= q_item.cls;
            key_reg <= q_item.key;
        end
        if (out_load) begin
            m_emit_reg   <= res_emit_reg;
            m_key_reg    <= res_emit_reg ? key_reg : '0;
            m_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= key_reg;
        end
        if (wr_emit_en) begin
            emitted_mem[wr_addr] <= wr_emit_val;
        end
        if (rd_en) begin
            rd_key_reg     <= key_mem[issue_reg[AW-1:0]];
            rd_emitted_reg <= emitted_mem[issue_reg[AW-1:0]];
            rd_idx_reg     <= issue_reg[AW-1:0];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && q_item.cls == CLS_CLEAR) |=> (count_reg == '0))
        else $error("Table count not cleared after a clear request.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == '0 || count_reg == $past(count_reg) + CW'(1)))
        else $error("Table count moved by more than one entry.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_emit) |-> !m_status)
        else $error("A result both emits and reports a dropped insert.");

endmodule

// ===== hw/rtl/set_intersection_dedup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_intersection_dedup_core
// Streaming set intersection with a duplicate-free, probe-ordered output.
//
//   Channel  Ports                                   Direction
//   s_       s_valid s_ready s_opcode s_key         request in
//   m_       m_valid m_ready m_emit m_match_key     result out
//            m_status
//
// An insert or probe scans the key memory one entry per cycle through its
// single read port.
// A clear or an unused opcode goes straight to the result without a scan.
// Reset empties the table through its fill count; there is no clearing pass.
// A two-entry request queue and the result register let each side stall alone.
// ----------------------------------------------------------------------------
module set_intersection_dedup_core import sid_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_opcode,
    input  logic signed [KEY_W-1:0] s_key,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_emit,
    output logic signed [KEY_W-1:0] m_match_key,
    output logic                    m_status
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    sid_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .s_key    (s_key),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sid_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_emit      (m_emit),
        .m_match_key (m_match_key),
        .m_status    (m_status)
    );

endmodule

// ===== dv/tb_set_intersection_dedup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_intersection_dedup_core
// Self-checking bench for the set intersection engine. A directed opening
// hits extreme keys, repeats, misses, clears and the unused opcode. Random
// episodes then load key pools, probe them with hits and misses, fill the
// table past capacity and mix in noise. Every accepted request is run through
// a local membership-table predictor, and each result is compared field by
// field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_set_intersection_dedup_core import sid_pkg::*;;

    localparam int         TABLE_DEPTH   = CAPACITY_DEFAULT;
    localparam int         RANDOM_ITEMS  = 1950;
    localparam int         FULL_EPISODES = 3;
    localparam int         CALM_FROM     = 30000;
    localparam int         CALM_TO       = 90000;
    localparam int         DRAIN_CYCLES  = 2 * TABLE_DEPTH + 50;
    localparam logic [1:0] OPC_UNUSED    = 2'd3;

    typedef struct {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
    } sid_request_t;

    typedef struct {
        logic             emit;
        logic [KEY_W-1:0] match_key;
        logic             status;
    } sid_result_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_opcode    = OPC_INSERT;
    logic signed [KEY_W-1:0] s_key       = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic                    m_emit;
    logic signed [KEY_W-1:0] m_match_key;
    logic                    m_status;

    sid_request_t     pending_requests[$];
    sid_result_t      expected_results[$];
    logic [KEY_W-1:0] table_keys[TABLE_DEPTH];
    logic             table_emitted[TABLE_DEPTH];
    int               table_fill     = 0;
    int               request_count  = 0;
    int               mismatches     = 0;
    int               cycle_count    = 0;
    logic             req_taken      = 1'b0;

    set_intersection_dedup_core #(
        .CAPACITY(TABLE_DEPTH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_key      (s_key),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_emit     (m_emit),
        .m_match_key(m_match_key),
        .m_status   (m_status)
    );

    always #4 aclk = ~aclk;

    function automatic sid_result_t predict_intersection(input logic [1:0] op,
                                                         input logic [KEY_W-1:0] k);
        sid_result_t res;
        int          hit;
        res = '{emit: 1'b0, match_key: '0, status: 1'b0};
        hit = -1;
        for (int i = 0; i < table_fill; i++) begin
            if (hit < 0 && table_keys[i] == k) begin
                hit = i;
            end
        end
        case (op)
            OPC_INSERT: begin
                if (hit < 0) begin
                    if (table_fill < TABLE_DEPTH) begin
                        table_keys[table_fill]    = k;
                        table_emitted[table_fill] = 1'b0;
                        table_fill++;
                    end else begin
                        res.status = 1'b1;
                    end
                end
            end
            OPC_PROBE: begin
                if (hit >= 0 && !table_emitted[hit]) begin
                    table_emitted[hit] = 1'b1;
                    res.emit           = 1'b1;
                    res.match_key      = k;
                end
            end
            OPC_CLEAR: begin
                table_fill = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 13;
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [KEY_W-1:0] k);
        sid_request_t new_req;
        new_req.opcode = op;
        new_req.key    = k;
        pending_requests.insert(pending_requests.size(), new_req);
        if (op != OPC_UNUSED) begin
            request_count++;
        end
    endtask

    task automatic wait_all_done();
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(negedge aclk) begin
        sid_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
            if (!s_valid || req_taken) begin
                if (pending_requests.size() != 0 && !idle_now()) begin
                    req = pending_requests.pop_front();
                    s_valid  <= 1'b1;
                    s_opcode <= req.opcode;
                    s_key    <= req.key;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        sid_result_t exp_res;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                exp_res = predict_intersection(s_opcode, s_key);
                expected_results.insert(expected_results.size(), exp_res);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result without a pending request: emit %0b match_key %h status %0b",
                           m_emit, m_match_key, m_status);
                    mismatches++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_emit !== exp_res.emit) begin
                        $error("emit: expected %0b, actual %0b", exp_res.emit, m_emit);
                        mismatches++;
                    end
                    if (m_match_key !== exp_res.match_key) begin
                        $error("match_key: expected %h, actual %h",
                               exp_res.match_key, m_match_key);
                        mismatches++;
                    end
                    if (m_status !== exp_res.status) begin
                        $error("status: expected %0b, actual %0b", exp_res.status, m_status);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #(40_000_000);
        $display("tb_set_intersection_dedup_core NOT OK");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] key_pool[24];
        logic [KEY_W-1:0] full_keys[TABLE_DEPTH];
        logic [KEY_W-1:0] k;
        int               pool_size;
        int               n_items;
        int               r;
        int               fulls;
        int               episode;

        push_request(OPC_PROBE,  32'h8000_0000);
        push_request(OPC_INSERT, 32'h8000_0000);
        push_request(OPC_INSERT, 32'h7FFF_FFFF);
        push_request(OPC_INSERT, 32'h0000_0000);
        push_request(OPC_INSERT, 32'hFFFF_FFFF);
        push_request(OPC_INSERT, 32'h8000_0000);
        push_request(OPC_PROBE,  32'h7FFF_FFFF);
        push_request(OPC_PROBE,  32'h7FFF_FFFF);
        push_request(OPC_PROBE,  32'hFFFF_FFFF);
        push_request(OPC_PROBE,  32'h0000_0001);
        push_request(OPC_PROBE,  32'h8000_0000);
        push_request(OPC_UNUSED, 32'hFFFF_FFFF);
        push_request(OPC_UNUSED, 32'h0000_0000);
        push_request(OPC_CLEAR,  32'hFFFF_FFFF);
        push_request(OPC_PROBE,  32'h0000_0000);
        push_request(OPC_INSERT, 32'h0000_0000);
        push_request(OPC_PROBE,  32'h0000_0000);
        push_request(OPC_INSERT, 32'h5555_5555);
        push_request(OPC_INSERT, 32'hAAAA_AAAA);
        push_request(OPC_PROBE,  32'hAAAA_AAAA);
        push_request(OPC_PROBE,  32'h5555_5555);
        push_request(OPC_CLEAR,  32'h0000_0000);
        push_request(OPC_PROBE,  32'h5555_5555);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // The sender holds off here until the directed requests have all drained.
        wait_all_done();

        request_count = 0;
        fulls         = 0;
        episode       = 0;
        while (request_count < RANDOM_ITEMS) begin
            if (episode % 8 == 3 && fulls < FULL_EPISODES) begin
                fulls++;
                push_request(OPC_CLEAR, $urandom);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    full_keys[i] = $urandom;
                    push_request(OPC_INSERT, full_keys[i]);
                    if ($urandom_range(15) == 0) begin
                        push_request(OPC_INSERT, full_keys[$urandom_range(i)]);
                    end
                    if ($urandom_range(15) == 0) begin
                        push_request(OPC_PROBE, full_keys[$urandom_range(i)]);
                    end
                end
                for (int i = 0; i < 18; i++) begin
                    if (i % 3 == 0) begin
                        push_request(OPC_INSERT, full_keys[$urandom_range(TABLE_DEPTH - 1)]);
                    end else begin
                        push_request(OPC_INSERT, $urandom);
                    end
                end
                for (int i = 0; i < 40; i++) begin
                    if ($urandom_range(3) != 0) begin
                        push_request(OPC_PROBE, full_keys[$urandom_range(TABLE_DEPTH - 1)]);
                    end else begin
                        push_request(OPC_PROBE, $urandom);
                    end
                end
            end else begin
                if ($urandom_range(3) != 0) begin
                    push_request(OPC_CLEAR, $urandom);
                end
                pool_size = $urandom_range(24, 1);
                for (int i = 0; i < pool_size; i++) begin
                    if ($urandom_range(3) == 0) begin
                        key_pool[i] = $urandom_range(15);
                    end else begin
                        key_pool[i] = $urandom;
                    end
                end
                n_items = $urandom_range(50, 8);
                for (int i = 0; i < n_items; i++) begin
                    r = $urandom_range(99);
                    k = key_pool[$urandom_range(pool_size - 1)];
                    if (r < 35) begin
                        push_request(OPC_INSERT, k);
                    end else if (r < 85) begin
                        if ($urandom_range(3) == 0) begin
                            k = $urandom;
                        end
                        push_request(OPC_PROBE, k);
                    end else if (r < 92) begin
                        push_request(OPC_INSERT, $urandom);
                    end else if (r < 96) begin
                        push_request(OPC_UNUSED, $urandom);
                    end else begin
                        push_request(OPC_CLEAR, $urandom);
                    end
                end
            end
            episode++;
        end

        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_set_intersection_dedup_core OK");
        end else begin
            $display("tb_set_intersection_dedup_core NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/sid_pkg.sv
hw/rtl/sid_front.sv
hw/rtl/sid_back.sv
hw/rtl/set_intersection_dedup_core.sv
dv/tb_set_intersection_dedup_core.sv
